/* design/bkt_pkg.sv */
// Package for the keyword tokenizer: keyword table, character helpers and
// the command and status types between controller and datapath.
// No dependencies.
package bkt_pkg;

    localparam int WIN_DEPTH = 11;
    localparam int KW_COUNT  = 93;
    localparam int KW_CHARS  = 11;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef logic [7:0] byte_t;
    typedef logic [3:0] fill_t;

    // Key text is right aligned: first char sits in the highest nonzero byte
    typedef struct packed {
        logic [8*KW_CHARS-1:0] text;
        byte_t                 token;
    } kw_entry_t;

    typedef struct packed {
        logic append;
        logic decide;
        logic flush;
    } bkt_cmd_t;

    typedef struct packed {
        logic fill_almost;
        logic drains;
        logic out_free;
    } bkt_status_t;

    function automatic byte_t up_case(input byte_t c);
        return (c >= 8'h61 && c <= 8'h7A) ? byte_t'(c - 8'd32) : c;
    endfunction

    function automatic logic is_alnum(input byte_t c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic int kw_len(input kw_entry_t e);
        int n;
        n = 0;
        for (int i = 0; i < KW_CHARS; i++)
        begin
            if (e.text[8*i +: 8] != 8'h00)
                n++;
        end
        return n;
    endfunction

    function automatic byte_t kw_char(input kw_entry_t e, input int len, input int i);
        int pos;
        pos = len - 1 - i;
        if (pos < 0)
            return 8'h00;
        return e.text[8*pos +: 8];
    endfunction

    // Keyword table in ascending byte order of the key text
    function automatic kw_entry_t kw_rom(input int idx);
        kw_entry_t e;
        e = '0;
        case (idx)
            0:  e = {88'(" ABS "), 8'hBD};
            1:  e = {88'(" ACS "), 8'hB6};
            2:  e = {88'(" AND "), 8'hC6};
            3:  e = {88'(" ASN "), 8'hB5};
            4:  e = {88'(" AT "), 8'hAC};
            5:  e = {88'(" ATN "), 8'hB7};
            6:  e = {88'(" ATTR "), 8'hAB};
            7:  e = {88'(" BEEP "), 8'hD7};
            8:  e = {88'(" BIN "), 8'hC4};
            9:  e = {88'(" BORDER "), 8'hE7};
            10: e = {88'(" BRIGHT "), 8'hDC};
            11: e = {88'(" CAT "), 8'hCF};
            12: e = {88'(" CHR$ "), 8'hC2};
            13: e = {88'(" CIRCLE "), 8'hD8};
            14: e = {88'(" CLEAR "), 8'hFD};
            15: e = {88'(" CLOSE #"), 8'hD4};
            16: e = {88'(" CLS "), 8'hFB};
            17: e = {88'(" CODE "), 8'hAF};
            18: e = {88'(" CONTINUE "), 8'hE8};
            19: e = {88'(" COPY "), 8'hFF};
            20: e = {88'(" COS "), 8'hB3};
            21: e = {88'(" DATA "), 8'hE4};
            22: e = {88'(" DEF FN "), 8'hCE};
            23: e = {88'(" DIM "), 8'hE9};
            24: e = {88'(" DRAW "), 8'hFC};
            25: e = {88'(" ERASE "), 8'hD2};
            26: e = {88'(" EXP "), 8'hB9};
            27: e = {88'(" FLASH "), 8'hDB};
            28: e = {88'(" FN "), 8'hA8};
            29: e = {88'(" FOR "), 8'hEB};
            30: e = {88'(" FORMAT "), 8'hD0};
            31: e = {88'(" GO SUB "), 8'hED};
            32: e = {88'(" GO TO "), 8'hEC};
            33: e = {88'(" IF "), 8'hFA};
            34: e = {88'(" IN "), 8'hBF};
            35: e = {88'(" INK "), 8'hD9};
            36: e = {88'(" INPUT "), 8'hEE};
            37: e = {88'(" INT "), 8'hBA};
            38: e = {88'(" INVERSE "), 8'hDD};
            39: e = {88'(" LEN "), 8'hB1};
            40: e = {88'(" LET "), 8'hF1};
            41: e = {88'(" LINE "), 8'hCA};
            42: e = {88'(" LIST "), 8'hF0};
            43: e = {88'(" LLIST "), 8'hE1};
            44: e = {88'(" LN "), 8'hB8};
            45: e = {88'(" LOAD "), 8'hEF};
            46: e = {88'(" LPRINT "), 8'hE0};
            47: e = {88'(" MERGE "), 8'hD5};
            48: e = {88'(" MOVE "), 8'hD1};
            49: e = {88'(" NEW "), 8'hE6};
            50: e = {88'(" NEXT "), 8'hF3};
            51: e = {88'(" NOT "), 8'hC3};
            52: e = {88'(" OPEN #"), 8'hD3};
            53: e = {88'(" OR "), 8'hC5};
            54: e = {88'(" OUT "), 8'hDF};
            55: e = {88'(" OVER "), 8'hDE};
            56: e = {88'(" PAPER "), 8'hDA};
            57: e = {88'(" PAUSE "), 8'hF2};
            58: e = {88'(" PEEK "), 8'hBE};
            59: e = {88'(" PLAY "), 8'hA4};
            60: e = {88'(" PLOT "), 8'hF6};
            61: e = {88'(" POINT "), 8'hA9};
            62: e = {88'(" POKE "), 8'hF4};
            63: e = {88'(" PRINT "), 8'hF5};
            64: e = {88'(" RANDOMIZE "), 8'hF9};
            65: e = {88'(" READ "), 8'hE3};
            66: e = {88'(" REM "), 8'hEA};
            67: e = {88'(" RESTORE "), 8'hE5};
            68: e = {88'(" RETURN "), 8'hFE};
            69: e = {88'(" RUN "), 8'hF7};
            70: e = {88'(" SAVE "), 8'hF8};
            71: e = {88'(" SGN "), 8'hBC};
            72: e = {88'(" SIN "), 8'hB2};
            73: e = {88'(" SPECTRUM "), 8'hA3};
            74: e = {88'(" SQR "), 8'hBB};
            75: e = {88'(" STEP "), 8'hCD};
            76: e = {88'(" STOP "), 8'hE2};
            77: e = {88'(" TAB "), 8'hAD};
            78: e = {88'(" TAN "), 8'hB4};
            79: e = {88'(" THEN "), 8'hCB};
            80: e = {88'(" TO "), 8'hCC};
            81: e = {88'(" USR "), 8'hC0};
            82: e = {88'(" VAL "), 8'hB0};
            83: e = {88'(" VERIFY "), 8'hD6};
            84: e = {88'("<="), 8'hC7};
            85: e = {88'("<>"), 8'hC9};
            86: e = {88'(">="), 8'hC8};
            87: e = {88'("INKEY$"), 8'hA6};
            88: e = {88'("PI"), 8'hA7};
            89: e = {88'("RND"), 8'hA5};
            90: e = {88'("SCREEN$ "), 8'hAA};
            91: e = {88'("STR$ "), 8'hC1};
            92: e = {88'("VAL$ "), 8'hAE};
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

/* design/basic_keyword_tokenizer_core.sv */
// Top level of the keyword tokenizer: controller plus datapath.
// Depends on bkt_pkg, bkt_ctrl, bkt_datapath.
//
// Input channel (in_valid/in_stall) carries one text character per request,
// with end_of_text on the final character. Output channel (out_valid/
// out_stall) carries token codes or copied characters; last_byte marks the
// final byte of a text. immediate_mode is written through cfg_we/cfg_data.
// Characters fill an 11-entry lookahead window. Once the window is full,
// the block decides the head against all keywords at once and loads the
// output register before it accepts a further character. On end_of_text
// the block drains the window, one output byte per cycle while the output
// is not stalled (up to 11), before it takes the next character.
// A decision waits while the output register holds an unaccepted byte under
// stall; in_stall stays high meanwhile, so no character is accepted.
// Reset empties the window, clears quote state, selects program mode and
// drops out_valid. No clearing pass is needed.
module basic_keyword_tokenizer_core
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_in,
    input  logic       end_of_text,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last_byte
);

    bkt_pkg::bkt_cmd_t    cmd;
    bkt_pkg::bkt_status_t status;

    bkt_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .end_of_text (end_of_text),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .status      (status)
    );

    bkt_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .char_in   (char_in),
        .out_byte  (out_byte),
        .last_byte (last_byte),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

endmodule

/* design/bkt_match.sv */
// Parallel keyword comparators against the window head, first hit wins.
// Depends on bkt_pkg.
module bkt_match
(
    input  bkt_pkg::byte_t win [bkt_pkg::WIN_DEPTH],
    input  bkt_pkg::fill_t fill,
    input  logic           immediate_mode,
    input  bkt_pkg::byte_t prior_char,
    input  logic           at_start,
    output logic           hit,
    output bkt_pkg::byte_t token,
    output bkt_pkg::fill_t count
);

    always_comb
    begin
        bkt_pkg::kw_entry_t e;
        int    len;
        int    tl;
        int    s;
        logic  lead;
        logic  trail;
        logic  ok;
        logic  nxt_ok;
        bkt_pkg::fill_t tli;
        bkt_pkg::fill_t n;
        hit    = 1'b0;
        token  = '0;
        count  = '0;
        s      = 0;
        tl     = 0;
        tli    = '0;
        nxt_ok = 1'b0;
        // Walk from the end so the lowest matching entry is the one kept
        for (int k = bkt_pkg::KW_COUNT - 1; k >= 0; k--)
        begin
            e     = bkt_pkg::kw_rom(k);
            len   = bkt_pkg::kw_len(e);
            lead  = (bkt_pkg::kw_char(e, len, 0) == bkt_pkg::CH_SPACE);
            trail = (bkt_pkg::kw_char(e, len, len - 1) == bkt_pkg::CH_SPACE);
            if (!immediate_mode)
            begin
                ok = (len <= int'(fill));
                for (int i = 0; i < bkt_pkg::WIN_DEPTH; i++)
                begin
                    if (i < len && bkt_pkg::up_case(win[i]) != bkt_pkg::kw_char(e, len, i))
                        ok = 1'b0;
                end
                n = bkt_pkg::fill_t'(len);
            end
            else
            begin
                s   = int'(lead);
                tl  = len - int'(lead) - int'(trail);
                tli = bkt_pkg::fill_t'(tl);
                ok  = (tl <= int'(fill));
                for (int i = 0; i < bkt_pkg::WIN_DEPTH; i++)
                begin
                    if (i < tl &&
                        bkt_pkg::up_case(win[i]) != bkt_pkg::kw_char(e, len, s + i))
                        ok = 1'b0;
                end
                // word boundaries on both sides
                if (!at_start && bkt_pkg::is_alnum(prior_char))
                    ok = 1'b0;
                nxt_ok = (tli < fill);
                if (nxt_ok && bkt_pkg::is_alnum(win[tli]))
                    ok = 1'b0;
                n = tli;
                if (trail && nxt_ok && win[tli] == bkt_pkg::CH_SPACE)
                    n = bkt_pkg::fill_t'(tl + 1);
            end
            if (ok)
            begin
                hit   = 1'b1;
                token = e.token;
                count = n;
            end
        end
    end

endmodule

/* design/bkt_datapath.sv */
// Datapath: lookahead window, text state, head decision and output register.
// Depends on bkt_pkg and bkt_match.
module bkt_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  bkt_pkg::bkt_cmd_t   cmd,
    output bkt_pkg::bkt_status_t status,
    input  logic                cfg_we,
    input  logic                cfg_data,
    input  bkt_pkg::byte_t      char_in,
    output bkt_pkg::byte_t      out_byte,
    output logic                last_byte,
    output logic                out_valid,
    input  logic                out_stall
);

    bkt_pkg::byte_t win_reg [bkt_pkg::WIN_DEPTH];
    bkt_pkg::fill_t fill_reg;
    logic           quote_reg;
    bkt_pkg::byte_t prior_reg;
    logic           start_reg;
    logic           mode_reg;
    logic           out_valid_reg;
    bkt_pkg::byte_t out_byte_reg;
    logic           last_reg;

    logic           hit;
    bkt_pkg::byte_t kw_token;
    bkt_pkg::fill_t kw_count;
    bkt_pkg::byte_t emit;
    bkt_pkg::fill_t take;
    logic           quote_next;

    bkt_match u_match
    (
        .win            (win_reg),
        .fill           (fill_reg),
        .immediate_mode (mode_reg),
        .prior_char     (prior_reg),
        .at_start       (start_reg),
        .hit            (hit),
        .token          (kw_token),
        .count          (kw_count)
    );

    // Head decision: quote toggle, literal copy, keyword or plain copy
    always_comb
    begin
        emit       = win_reg[0];
        take       = 4'd1;
        quote_next = quote_reg;
        if (win_reg[0] == bkt_pkg::CH_QUOTE)
            quote_next = ~quote_reg;
        else if (!quote_reg && hit)
        begin
            emit = kw_token;
            take = kw_count;
        end
    end

    assign status.fill_almost = (fill_reg == bkt_pkg::fill_t'(bkt_pkg::WIN_DEPTH - 1));
    assign status.drains      = (take == fill_reg);
    assign status.out_free    = !out_valid_reg || !out_stall;

    // Window shift / append
    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            for (int j = 0; j < bkt_pkg::WIN_DEPTH; j++)
            begin
                if (j + int'(take) < bkt_pkg::WIN_DEPTH)
                    win_reg[j] <= win_reg[bkt_pkg::fill_t'(j + int'(take))];
            end
            prior_reg <= win_reg[take - 4'd1];
        end
        else if (cmd.append)
            win_reg[fill_reg] <= char_in;
    end

    // Text state and mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            quote_reg <= 1'b0;
            start_reg <= 1'b1;
            mode_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                mode_reg <= cfg_data;
            if (cmd.decide)
            begin
                fill_reg  <= fill_reg - take;
                quote_reg <= quote_next;
                start_reg <= 1'b0;
                if (cmd.flush && status.drains)
                begin
                    quote_reg <= 1'b0;
                    start_reg <= 1'b1;
                end
            end
            else if (cmd.append)
                fill_reg <= fill_reg + 4'd1;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.decide)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            out_byte_reg <= emit;
            last_reg     <= cmd.flush && status.drains;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last_byte = last_reg;

endmodule

/* design/bkt_ctrl.sv */
// Controller: accepts characters and sequences head decisions and flushes.
// Depends on bkt_pkg.
module bkt_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 end_of_text,
    output logic                 in_stall,
    output bkt_pkg::bkt_cmd_t    cmd,
    input  bkt_pkg::bkt_status_t status
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ONE   = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.append = 1'b1;
                    if (end_of_text)
                        state_next = ST_FLUSH;
                    else if (status.fill_almost)
                        state_next = ST_ONE;
                end
            end
            ST_ONE:
            begin
                if (status.out_free)
                begin
                    cmd.decide = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                if (status.out_free)
                begin
                    cmd.decide = 1'b1;
                    cmd.flush  = 1'b1;
                    if (status.drains)
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
